@@ sv/csb_pkg.sv @@
package csb_pkg;

  // Fixed field widths of the channels
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Defaults for the top level parameters
  localparam int DEPTH_DEF      = 64;
  localparam int WORD_WIDTH_DEF = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CURRENT = 2'd2;

endpackage

@@ sv/csb_cmd_if.sv @@
interface csb_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [csb_pkg::CMD_W-1:0]   cmd;
  logic [csb_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

@@ sv/csb_res_if.sv @@
interface csb_res_if #(
  parameter int CNT_W = 7
);
  logic                         valid;
  logic                         ready;
  logic                         has_current;
  logic [csb_pkg::VALUE_W-1:0]  current_value;
  logic [CNT_W-1:0]             count;
  logic [csb_pkg::STATUS_W-1:0] status;

  modport source (output valid, output has_current, output current_value, output count,
                  output status, input ready);
  modport sink (input valid, input has_current, input current_value, input count,
                input status, output ready);
endinterface

@@ sv/csb_mem.sv @@
module csb_mem #(
  parameter int  DEPTH      = csb_pkg::DEPTH_DEF,
  parameter int  WORD_WIDTH = csb_pkg::WORD_WIDTH_DEF,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WORD_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WORD_WIDTH-1:0] rdata
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/csb_seq.sv @@
module csb_seq #(
  parameter int  DEPTH      = csb_pkg::DEPTH_DEF,
  parameter int  WORD_WIDTH = csb_pkg::WORD_WIDTH_DEF,
  localparam int AW         = $clog2(DEPTH),
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  csb_cmd_if.sink               in_chan,
  csb_res_if.source             out_chan,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [WORD_WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [WORD_WIDTH-1:0] mem_rdata
);

  import csb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      cursor_r, cursor_nxt;
  logic [CNT_W-1:0]      src_r, src_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [AW-1:0]         pa_r, pa_nxt;
  logic                  pw_r, pw_nxt;
  logic                  up_r, up_nxt;
  logic                  put_r, put_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [WORD_WIDTH-1:0] word_r, word_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_has_r, out_has_nxt;
  logic [VALUE_W-1:0]    out_val_r, out_val_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic                  accept;
  logic                  cur_valid;
  logic                  full;
  logic [CNT_W-1:0]      pos;
  logic [63:0]           in_ext;
  logic [63:0]           rd_ext;

  assign accept    = in_chan.valid && in_chan.ready;
  assign cur_valid = cursor_r < count_r;
  assign full      = count_r == CNT_W'(DEPTH);
  assign in_ext    = 64'(in_chan.value);
  assign rd_ext    = 64'(mem_rdata);

  // Target slot of an insert or attach
  always_comb begin
    if (in_chan.cmd == CMD_INSERT) begin
      pos = cur_valid ? cursor_r : '0;
    end else begin
      pos = cur_valid ? cursor_r + CNT_W'(1) : count_r;
    end
  end

  // Sequencer: decode, shift through memory, write new word, read back, respond
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    src_nxt        = src_r;
    rem_nxt        = rem_r;
    pa_nxt         = pa_r;
    pw_nxt         = pw_r;
    up_nxt         = up_r;
    put_nxt        = put_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_has_nxt    = out_has_r;
    out_val_nxt    = out_val_r;
    out_cnt_nxt    = out_cnt_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = pa_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = src_r[AW-1:0];

    // Drop the result once the sink takes it
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          word_nxt   = in_ext[WORD_WIDTH-1:0];
          state_nxt  = S_READ;
          unique case (in_chan.cmd)
            CMD_START: begin
              cursor_nxt = '0;
            end
            CMD_ADVANCE: begin
              if (!cur_valid) begin
                status_nxt = ST_NO_CURRENT;
              end else begin
                cursor_nxt = cursor_r + CNT_W'(1);
              end
            end
            CMD_INSERT, CMD_ATTACH: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                cursor_nxt = pos;
                pos_nxt    = pos[AW-1:0];
                rem_nxt    = count_r - pos;
                src_nxt    = count_r - CNT_W'(1);
                up_nxt     = 1'b1;
                put_nxt    = 1'b1;
                pw_nxt     = 1'b0;
                count_nxt  = count_r + CNT_W'(1);
                state_nxt  = S_SHIFT;
              end
            end
            CMD_REMOVE: begin
              if (!cur_valid) begin
                status_nxt = ST_NO_CURRENT;
              end else begin
                rem_nxt   = count_r - CNT_W'(1) - cursor_r;
                src_nxt   = cursor_r + CNT_W'(1);
                up_nxt    = 1'b0;
                put_nxt   = 1'b0;
                pw_nxt    = 1'b0;
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        // Retire the move whose source was read last cycle
        mem_we = pw_r;
        if (rem_r != '0) begin
          mem_re  = 1'b1;
          pw_nxt  = 1'b1;
          rem_nxt = rem_r - CNT_W'(1);
          if (up_r) begin
            pa_nxt  = AW'(src_r + CNT_W'(1));
            src_nxt = src_r - CNT_W'(1);
          end else begin
            pa_nxt  = AW'(src_r - CNT_W'(1));
            src_nxt = src_r + CNT_W'(1);
          end
        end else begin
          pw_nxt    = 1'b0;
          state_nxt = put_r ? S_PUT : S_READ;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = word_r;
        state_nxt = S_READ;
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = cursor_r[AW-1:0];
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Hold until the result register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_has_nxt    = cur_valid;
          out_val_nxt    = cur_valid ? rd_ext[VALUE_W-1:0] : '0;
          out_cnt_nxt    = count_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      pw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      pw_r        <= pw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    rem_r        <= rem_nxt;
    pa_r         <= pa_nxt;
    up_r         <= up_nxt;
    put_r        <= put_nxt;
    pos_r        <= pos_nxt;
    word_r       <= word_nxt;
    status_r     <= status_nxt;
    out_has_r    <= out_has_nxt;
    out_val_r    <= out_val_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_chan.ready          = state_r == S_IDLE;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.has_current   = out_has_r;
  assign out_chan.current_value = out_val_r;
  assign out_chan.count         = out_cnt_r;
  assign out_chan.status        = out_status_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("cursor beyond end of buffer");

  a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && pw_r && rem_r != '0) |-> pa_r != src_r[AW-1:0])
    else $error("shift write collides with shift read");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.cmd == CMD_INSERT || in_chan.cmd == CMD_ATTACH) && !full)
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the buffer");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.cmd == CMD_REMOVE && cur_valid)
    |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not shrink the buffer");
`endif

endmodule

@@ sv/cursor_sequence_buffer.sv @@
// Ordered buffer of up to DEPTH words with a cursor on the current entry.
// in_chan carries one command per transfer: start, advance, insert before,
// attach after, remove current or read, with a word for insert and attach.
// out_chan returns one result per command: whether a current entry exists,
// its word (zero if none), the entry count and a status code.
// Words live in a single-port-write, single-port-read memory with a
// registered read. Insert, attach and remove move the entries
// behind the cursor one per cycle through that memory, reading one slot
// while the previous move is written back.
// Start, advance and read read the cursor slot, then register the result.
// Insert and attach first move the n entries from the target slot up, then
// write the new word and read back; remove moves the n entries behind the
// cursor down, then reads back; n is at most DEPTH - 1. One command is in
// work at a time; a new one is taken after the previous result is registered.
// A finished result waits in the output register while the receiver stalls;
// the next command is accepted meanwhile and its result holds until then.
// Reset empties the buffer and puts the cursor at the front; memory contents
// are left as they are and only words below the entry count are returned.
module cursor_sequence_buffer #(
  parameter int DEPTH      = csb_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = csb_pkg::WORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  csb_cmd_if.sink   in_chan,
  csb_res_if.source out_chan
);

  import csb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_WIDTH-1:0] mem_rdata;

  // Command sequencer and result register
  csb_seq #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry storage
  csb_mem #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
